/* design/bfm_pkg.sv */
// Shared types, sizes and character codes for the brainfuck machine.
`default_nettype none
package bfm_pkg;

  localparam int TAPE_DEPTH  = 32768;
  localparam int STACK_DEPTH = 64;
  localparam int PROG_DEPTH  = 4096;
  localparam int CELL_BITS   = 8;
  localparam int RUN_BUDGET  = 65536;

  localparam int PROG_AW  = $clog2(PROG_DEPTH);
  localparam int PC_W     = $clog2(PROG_DEPTH + 1);
  localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W   = $clog2(RUN_BUDGET + 1);

  localparam logic [7:0] CH_RIGHT   = 8'h3E;
  localparam logic [7:0] CH_LEFT    = 8'h3C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_OUTPUT    = 3'd0,
    ST_INPUT     = 3'd1,
    ST_HALT      = 3'd2,
    ST_UNDERRUN  = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_STACK     = 3'd5,
    ST_UNMATCHED = 3'd6
  } status_t;

  localparam logic [2:0] FAULT_NONE = 3'd0;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RUN,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] program_char;
    logic [7:0] input_byte;
    logic       input_eof;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
    logic clearing;
  } queue_ctl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_SCAN,
    S_SCANCHK,
    S_POP
  } state_t;

endpackage
`default_nettype wire

/* design/bfm_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module bfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/bfm_front.sv */
// Front end: accepts requests, classifies them and queues them for execution.
`default_nettype none
module bfm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_kind,
  input  wire logic [7:0]       in_program_char,
  input  wire logic [7:0]       in_input_byte,
  input  wire logic             in_input_eof,
  input  wire bfm_pkg::queue_ctl_t ctl_in,
  output bfm_pkg::queue_ctl_t   ctl_out,
  output bfm_pkg::item_t        q_item
);
  import bfm_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, keep;
  item_t      cls;

  always_comb begin
    cls.program_char = in_program_char;
    cls.input_byte   = in_input_byte;
    cls.input_eof    = in_input_eof;
    keep = 1'b1;
    case (in_kind)
      KIND_LOAD:  cls.op = OP_LOAD;
      KIND_RUN:   cls.op = OP_RUN;
      KIND_CLEAR: cls.op = OP_CLEAR;
      default: begin
        cls.op = OP_LOAD;
        keep   = 1'b0;  // drop unused kind
      end
    endcase
  end

  assign in_ready = (count_r != 2'd2) && !ctl_in.clearing;
  assign push     = in_valid && in_ready && keep;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push;
    rd_ptr_nxt = rd_ptr_r + ctl_in.pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, ctl_in.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_comb begin
    ctl_out          = '0;
    ctl_out.valid    = (count_r != 2'd0);
  end
  assign q_item = slot_r[rd_ptr_r];
endmodule
`default_nettype wire

/* design/bfm_exec.sv */
// Back end: program store, tape, loop stack and the instruction sequencer.
`default_nettype none
module bfm_exec (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bfm_pkg::queue_ctl_t ctl_in,
  input  wire bfm_pkg::item_t      q_item,
  output bfm_pkg::queue_ctl_t      ctl_out,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_status,
  output logic [7:0]               out_out_byte,
  output logic [11:0]              out_stop_address
);
  import bfm_pkg::*;

  state_t               state_r, state_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [PC_W-1:0]      plen_r, plen_nxt;
  logic [TAPE_AW-1:0]   dp_r, dp_nxt;
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic                 waiting_r, waiting_nxt;
  logic [2:0]           fault_r, fault_nxt;
  logic [STEP_W-1:0]    steps_r, steps_nxt;
  logic [PC_W-1:0]      scan_pos_r, scan_pos_nxt;
  logic [PC_W-1:0]      scan_depth_r, scan_depth_nxt;
  logic [TAPE_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic                 ov_r, ov_nxt;
  logic [2:0]           os_r, os_nxt;
  logic [7:0]           ob_r, ob_nxt;
  logic [11:0]          oa_r, oa_nxt;

  logic                 prog_we;
  logic [PROG_AW-1:0]   prog_raddr;
  logic [7:0]           prog_rdata;
  logic                 tape_we;
  logic [TAPE_AW-1:0]   tape_waddr;
  logic [CELL_BITS-1:0] tape_wdata, tape_rdata;
  logic                 stk_we;
  logic [STACK_AW-1:0]  stk_raddr;
  logic [PROG_AW-1:0]   stk_rdata;
  logic                 pop;

  bfm_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk, .we(prog_we), .waddr(plen_r[PROG_AW-1:0]), .wdata(q_item.program_char),
    .raddr(prog_raddr), .rdata(prog_rdata)
  );
  bfm_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk, .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .raddr(dp_r), .rdata(tape_rdata)
  );
  bfm_ram #(.WIDTH(PROG_AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(sp_r[STACK_AW-1:0]), .wdata(pc_r[PROG_AW-1:0]),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    plen_nxt       = plen_r;
    dp_nxt         = dp_r;
    sp_nxt         = sp_r;
    waiting_nxt    = waiting_r;
    fault_nxt      = fault_r;
    steps_nxt      = steps_r;
    scan_pos_nxt   = scan_pos_r;
    scan_depth_nxt = scan_depth_r;
    clr_addr_nxt   = clr_addr_r;
    ov_nxt         = ov_r && !out_ready;
    os_nxt         = os_r;
    ob_nxt         = ob_r;
    oa_nxt         = oa_r;
    prog_we        = 1'b0;
    prog_raddr     = pc_r[PROG_AW-1:0];
    tape_we        = 1'b0;
    tape_waddr     = dp_r;
    tape_wdata     = '0;
    stk_we         = 1'b0;
    stk_raddr      = STACK_AW'(sp_r - SP_W'(1));
    pop            = 1'b0;

    case (state_r)
      S_CLEAR: begin
        tape_we      = 1'b1;
        tape_waddr   = clr_addr_r;
        clr_addr_nxt = clr_addr_r + TAPE_AW'(1);
        if (clr_addr_r == TAPE_AW'(TAPE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (ctl_in.valid && !ov_r) begin
          pop = 1'b1;
          case (q_item.op)
            OP_LOAD: begin
              if (plen_r < PC_W'(PROG_DEPTH)) begin
                prog_we  = 1'b1;
                plen_nxt = plen_r + PC_W'(1);
              end
            end
            OP_CLEAR: begin
              pc_nxt       = '0;
              plen_nxt     = '0;
              dp_nxt       = '0;
              sp_nxt       = '0;
              waiting_nxt  = 1'b0;
              fault_nxt    = FAULT_NONE;
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            OP_RUN: begin
              steps_nxt = '0;
              if (fault_r != FAULT_NONE) begin
                ov_nxt = 1'b1;
                os_nxt = fault_r;
                ob_nxt = '0;
                oa_nxt = 12'(pc_r);
              end else begin
                if (waiting_r) begin
                  // store the supplied byte unless end of file or newline
                  if (!q_item.input_eof && q_item.input_byte != CH_NEWLINE) begin
                    tape_we    = 1'b1;
                    tape_wdata = CELL_BITS'(q_item.input_byte);
                  end
                  pc_nxt      = pc_r + PC_W'(1);
                  waiting_nxt = 1'b0;
                end
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (steps_r == STEP_W'(RUN_BUDGET)) begin
          state_nxt = S_IDLE;
        end else if (pc_r >= plen_r) begin
          ov_nxt    = 1'b1;
          os_nxt    = ST_HALT;
          ob_nxt    = '0;
          oa_nxt    = 12'(pc_r);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        steps_nxt = steps_r + STEP_W'(1);
        state_nxt = S_FETCH;
        ob_nxt    = '0;
        oa_nxt    = 12'(pc_r);
        case (prog_rdata)
          CH_RIGHT: begin
            if (dp_r == TAPE_AW'(TAPE_DEPTH - 1)) begin
              ov_nxt = 1'b1; os_nxt = ST_OVERRUN; fault_nxt = ST_OVERRUN;
              waiting_nxt = 1'b0; state_nxt = S_IDLE;
            end else begin
              dp_nxt = dp_r + TAPE_AW'(1);
              pc_nxt = pc_r + PC_W'(1);
            end
          end
          CH_LEFT: begin
            if (dp_r == '0) begin
              ov_nxt = 1'b1; os_nxt = ST_UNDERRUN; fault_nxt = ST_UNDERRUN;
              waiting_nxt = 1'b0; state_nxt = S_IDLE;
            end else begin
              dp_nxt = dp_r - TAPE_AW'(1);
              pc_nxt = pc_r + PC_W'(1);
            end
          end
          CH_PLUS: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + CELL_BITS'(1);
            pc_nxt     = pc_r + PC_W'(1);
          end
          CH_MINUS: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - CELL_BITS'(1);
            pc_nxt     = pc_r + PC_W'(1);
          end
          CH_DOT: begin
            ov_nxt    = 1'b1;
            os_nxt    = ST_OUTPUT;
            ob_nxt    = 8'(tape_rdata);
            pc_nxt    = pc_r + PC_W'(1);
            state_nxt = S_IDLE;
          end
          CH_COMMA: begin
            ov_nxt      = 1'b1;
            os_nxt      = ST_INPUT;
            waiting_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
          CH_OPEN: begin
            if (tape_rdata != '0) begin
              if (sp_r >= SP_W'(STACK_DEPTH)) begin
                ov_nxt = 1'b1; os_nxt = ST_STACK; fault_nxt = ST_STACK;
                waiting_nxt = 1'b0; state_nxt = S_IDLE;
              end else begin
                stk_we = 1'b1;
                sp_nxt = sp_r + SP_W'(1);
                pc_nxt = pc_r + PC_W'(1);
              end
            end else begin
              // skip forward to the matching close bracket
              scan_pos_nxt   = pc_r + PC_W'(1);
              scan_depth_nxt = PC_W'(1);
              state_nxt      = S_SCAN;
            end
          end
          CH_CLOSE: begin
            if (sp_r == '0) begin
              ov_nxt = 1'b1; os_nxt = ST_UNMATCHED; fault_nxt = ST_UNMATCHED;
              waiting_nxt = 1'b0; state_nxt = S_IDLE;
            end else if (tape_rdata != '0) begin
              state_nxt = S_POP;  // stack read is in flight
            end else begin
              sp_nxt = sp_r - SP_W'(1);
              pc_nxt = pc_r + PC_W'(1);
            end
          end
          default: pc_nxt = pc_r + PC_W'(1);
        endcase
      end
      S_SCAN: begin
        prog_raddr = scan_pos_r[PROG_AW-1:0];
        if (scan_pos_r >= plen_r) begin
          ov_nxt      = 1'b1;
          os_nxt      = ST_UNMATCHED;
          ob_nxt      = '0;
          oa_nxt      = 12'(pc_r);
          fault_nxt   = ST_UNMATCHED;
          waiting_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SCANCHK;
        end
      end
      S_SCANCHK: begin
        state_nxt    = S_SCAN;
        scan_pos_nxt = scan_pos_r + PC_W'(1);
        if (prog_rdata == CH_OPEN) begin
          scan_depth_nxt = scan_depth_r + PC_W'(1);
        end else if (prog_rdata == CH_CLOSE) begin
          scan_depth_nxt = scan_depth_r - PC_W'(1);
          if (scan_depth_r == PC_W'(1)) begin
            pc_nxt    = scan_pos_r + PC_W'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_POP: begin
        pc_nxt    = PC_W'(stk_rdata) + PC_W'(1);
        state_nxt = S_FETCH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      pc_r       <= '0;
      plen_r     <= '0;
      dp_r       <= '0;
      sp_r       <= '0;
      waiting_r  <= 1'b0;
      fault_r    <= FAULT_NONE;
      steps_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pc_r       <= pc_nxt;
      plen_r     <= plen_nxt;
      dp_r       <= dp_nxt;
      sp_r       <= sp_nxt;
      waiting_r  <= waiting_nxt;
      fault_r    <= fault_nxt;
      steps_r    <= steps_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_pos_r   <= scan_pos_nxt;
    scan_depth_r <= scan_depth_nxt;
    os_r         <= os_nxt;
    ob_r         <= ob_nxt;
    oa_r         <= oa_nxt;
  end

  always_comb begin
    ctl_out          = '0;
    ctl_out.pop      = pop;
    ctl_out.clearing = (state_r == S_CLEAR);
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_out_byte     = ob_r;
  assign out_stop_address = oa_r;
endmodule
`default_nettype wire

/* design/brainfuck_machine.sv */
// Top level of the brainfuck machine: request queue in front, executor behind.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  in       | in_valid/in_ready   | kind, program_char, input_byte, input_eof
//  out      | out_valid/out_ready | status, out_byte, stop_address
//
// A load request is taken in the idle state, a clear request starts the tape
// sweep, and a run request steps through fetch and decode for each executed
// instruction, the pop state for each jump back at a close bracket, and scan
// and scan-check for each character scanned when a zero cell skips a loop.
// Reset and every clear request start a zeroing sweep of all 32768 tape cells,
// one cell a cycle, during which in_ready stays low.
// The two-entry queue keeps accepting requests while a result waits on out, until it is full.
`default_nettype none
module brainfuck_machine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_program_char,
  input  wire logic [7:0]  in_input_byte,
  input  wire logic        in_input_eof,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_out_byte,
  output logic [11:0]      out_stop_address
);
  import bfm_pkg::*;

  queue_ctl_t front_ctl;  // queue holds a request
  queue_ctl_t exec_ctl;   // pop and tape sweep status
  item_t      q_item;

  // classify and hold requests until the executor is free
  bfm_front u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_kind, .in_program_char, .in_input_byte, .in_input_eof,
    .ctl_in(exec_ctl), .ctl_out(front_ctl), .q_item
  );

  // advance the program and drive the result register
  bfm_exec u_exec (
    .clk, .rst_n,
    .ctl_in(front_ctl), .q_item, .ctl_out(exec_ctl),
    .out_valid, .out_ready, .out_status, .out_out_byte, .out_stop_address
  );
endmodule
`default_nettype wire

/* design/bfm_checker.sv */
// Port-level checks for the brainfuck machine, bound to the top level.
`default_nettype none
module bfm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [7:0]  out_out_byte,
  input wire logic [11:0] out_stop_address
);
  import bfm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("outputs active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_stop_address) && $stable(out_out_byte))
    else $error("stalled result changed");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OUTPUT |-> out_out_byte == 8'd0)
    else $error("byte set on a non-output result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_UNMATCHED)
    else $error("status code out of range");
endmodule

bind brainfuck_machine bfm_checker u_bfm_checker (.*);
`default_nettype wire
